>>> hw/rtl/pcd_pkg.sv
// Shared types and constants for the PPM capture decoder.
`default_nettype none

package pcd_pkg;

  // Field widths of the channels
  localparam int unsigned CAPTURE_W = 32;
  localparam int unsigned WIDTH_W   = 16;
  localparam int unsigned INDEX_W   = 3;

  // Default number of stored channel slots
  localparam int unsigned CHANNELS_DEF = 8;

  // Ticks per microsecond is 48 = 16 * 3: shift out the 16, multiply by the reciprocal of 3
  localparam int unsigned DIV_SHIFT  = 4;
  localparam int unsigned PRE_W      = CAPTURE_W - DIV_SHIFT;          // 28
  localparam int unsigned RECIP_W    = 32;
  localparam int unsigned PROD_W     = PRE_W + RECIP_W;                // 60
  localparam int unsigned RECIP_SH   = 33;
  localparam int unsigned QUOT_W     = PROD_W - RECIP_SH;              // 27
  localparam logic [RECIP_W-1:0] RECIP3 = 32'hAAAA_AAAB;

  // Configuration register reset values
  localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST = 16'd800;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST = 16'd2200;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_WIDTH = 1'b0,
    CFG_MAX_WIDTH = 1'b1
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_DIV,
    ST_DECIDE,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_e;

  // One result item
  typedef struct packed {
    logic [INDEX_W-1:0] channel_index;
    logic [WIDTH_W-1:0] width;
    logic               last;
    logic               error;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/pcd_if.sv
// Handshake channel interfaces: capture input, result output, configuration write.
`default_nettype none

interface pcd_capture_if;
  logic                             valid;
  logic                             ready;
  logic [pcd_pkg::CAPTURE_W-1:0]    capture_value;
  logic                             from_pulse_channel;

  modport source (output valid, output capture_value, output from_pulse_channel,
                  input ready);
  modport sink   (input valid, input capture_value, input from_pulse_channel,
                  output ready);
endinterface

interface pcd_result_if;
  logic                             valid;
  logic                             ready;
  logic [pcd_pkg::INDEX_W-1:0]      channel_index;
  logic [pcd_pkg::WIDTH_W-1:0]      width;
  logic                             last;
  logic                             error;

  modport source (output valid, output channel_index, output width, output last,
                  output error, input ready);
  modport sink   (input valid, input channel_index, input width, input last,
                  input error, output ready);
endinterface

interface pcd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pcd_pkg::CFG_IDX_W-1:0]    index;
  logic [pcd_pkg::WIDTH_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pcd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module pcd_ram #(
  parameter  int unsigned WIDTH  = 16,
  parameter  int unsigned DEPTH  = 8,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ppm_capture_decoder_unit.sv
// Top level of the PPM capture decoder: width measurement, channel store, frame readout.
`default_nettype none

// The block turns timer captures of a PPM pulse train into channel widths in
// microseconds. Each capture from the pulse channel is subtracted from the
// previous one (modulo 2^32) and divided by 48 ticks per microsecond. A width
// within [min_width, max_width] goes into the next free slot of the channel
// store and yields no result; any other width (the sync gap, noise, or one
// channel too many) rewinds the slot index and sends out all CHANNELS slots as
// one frame, stale slots included, with last set on the final item. A capture
// from any other timer channel yields one item with error and last set and
// leaves the previous capture, slot index and store alone. Captures are taken
// one at a time: a width passes accept, divide and window check, an error item
// accept and the error step, and a frame then reads each slot from the store, a
// single-read memory with a registered read port, and moves it to the output
// register; stalls on the result side hold these steps. The store is cleared
// at reset by per-slot valid bits, so no clearing pass is needed. Configuration
// writes are always taken and should be issued only while the block is idle.
module ppm_capture_decoder_unit #(
  parameter int unsigned CHANNELS = pcd_pkg::CHANNELS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pcd_capture_if.sink  capture_i,
  pcd_result_if.source result_o,
  pcd_cfg_if.sink      cfg_i
);

  localparam int unsigned SLOT_W = $clog2(CHANNELS + 1);
  localparam int unsigned ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [pcd_pkg::WIDTH_W-1:0] min_width_q, max_width_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_width_q <= pcd_pkg::MIN_WIDTH_RST;
      max_width_q <= pcd_pkg::MAX_WIDTH_RST;
    end else if (cfg_i.valid) begin
      unique case (pcd_pkg::cfg_idx_e'(cfg_i.index))
        pcd_pkg::CFG_MIN_WIDTH: min_width_q <= cfg_i.data;
        pcd_pkg::CFG_MAX_WIDTH: max_width_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // State and datapath registers
  // ---------------------------------------------------------------------------
  pcd_pkg::state_e state_q, state_d;

  logic [pcd_pkg::CAPTURE_W-1:0] prev_capture_q;
  logic [pcd_pkg::CAPTURE_W-1:0] diff_q;
  logic [pcd_pkg::QUOT_W-1:0]    quot_q;
  logic [pcd_pkg::PROD_W-1:0]    prod;
  logic [SLOT_W-1:0]             next_slot_q, next_slot_d;
  logic [ADDR_W-1:0]             emit_idx_q, emit_idx_d;
  logic [CHANNELS-1:0]           slot_valid_q;

  logic                          res_valid_q, res_valid_d;
  pcd_pkg::result_t              res_q, res_d;

  // Control decoded from the state
  logic accept;
  logic store_we;
  logic store_re;
  logic res_load;
  logic in_window;
  logic emit_last;
  logic out_free;

  logic [pcd_pkg::WIDTH_W-1:0] store_rdata;

  // Divide by 48: drop four bits, then multiply by the reciprocal of 3
  assign prod = pcd_pkg::PROD_W'(diff_q[pcd_pkg::CAPTURE_W-1:pcd_pkg::DIV_SHIFT])
              * pcd_pkg::PROD_W'(pcd_pkg::RECIP3);

  assign in_window = (quot_q >= pcd_pkg::QUOT_W'(min_width_q))
                  && (quot_q <= pcd_pkg::QUOT_W'(max_width_q))
                  && (next_slot_q < SLOT_W'(CHANNELS));

  assign emit_last = (emit_idx_q == ADDR_W'(CHANNELS - 1));
  assign out_free  = !res_valid_q || result_o.ready;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcd_pkg::ST_IDLE: begin
        if (capture_i.valid) begin
          state_d = capture_i.from_pulse_channel ? pcd_pkg::ST_DIV : pcd_pkg::ST_ERR;
        end
      end
      pcd_pkg::ST_ERR: begin
        if (out_free) begin
          state_d = pcd_pkg::ST_IDLE;
        end
      end
      pcd_pkg::ST_DIV: begin
        state_d = pcd_pkg::ST_DECIDE;
      end
      pcd_pkg::ST_DECIDE: begin
        state_d = in_window ? pcd_pkg::ST_IDLE : pcd_pkg::ST_EMIT_RD;
      end
      pcd_pkg::ST_EMIT_RD: begin
        state_d = pcd_pkg::ST_EMIT_WR;
      end
      pcd_pkg::ST_EMIT_WR: begin
        if (out_free) begin
          state_d = emit_last ? pcd_pkg::ST_IDLE : pcd_pkg::ST_EMIT_RD;
        end
      end
      default: state_d = pcd_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs of the sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    capture_i.ready = 1'b0;
    store_we        = 1'b0;
    store_re        = 1'b0;
    res_load        = 1'b0;
    res_d           = res_q;
    next_slot_d     = next_slot_q;
    emit_idx_d      = emit_idx_q;
    unique case (state_q)
      pcd_pkg::ST_IDLE: begin
        capture_i.ready = 1'b1;
      end
      pcd_pkg::ST_ERR: begin
        res_load            = out_free;
        res_d.channel_index = '0;
        res_d.width         = '0;
        res_d.last          = 1'b1;
        res_d.error         = 1'b1;
      end
      pcd_pkg::ST_DIV: ;
      pcd_pkg::ST_DECIDE: begin
        if (in_window) begin
          // Store the width and advance to the next slot
          store_we    = 1'b1;
          next_slot_d = next_slot_q + SLOT_W'(1);
        end else begin
          // Sync gap or overflow: rewind and start the frame
          next_slot_d = '0;
          emit_idx_d  = '0;
        end
      end
      pcd_pkg::ST_EMIT_RD: begin
        store_re = 1'b1;
      end
      pcd_pkg::ST_EMIT_WR: begin
        res_load            = out_free;
        res_d.channel_index = pcd_pkg::INDEX_W'(emit_idx_q);
        res_d.width         = slot_valid_q[emit_idx_q] ? store_rdata : '0;
        res_d.last          = emit_last;
        res_d.error         = 1'b0;
        if (out_free && !emit_last) begin
          emit_idx_d = emit_idx_q + ADDR_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign accept = capture_i.valid && capture_i.ready;

  // Output register: hold until taken, reload when free
  always_comb begin
    res_valid_d = res_valid_q && !result_o.ready;
    if (res_load) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= pcd_pkg::ST_IDLE;
      prev_capture_q <= '0;
      next_slot_q    <= '0;
      emit_idx_q     <= '0;
      slot_valid_q   <= '0;
      res_valid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_slot_q <= next_slot_d;
      emit_idx_q  <= emit_idx_d;
      res_valid_q <= res_valid_d;
      if (accept && capture_i.from_pulse_channel) begin
        prev_capture_q <= capture_i.capture_value;
      end
      if (store_we) begin
        slot_valid_q[next_slot_q[ADDR_W-1:0]] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      diff_q <= capture_i.capture_value - prev_capture_q;
    end
    if (state_q == pcd_pkg::ST_DIV) begin
      quot_q <= prod[pcd_pkg::PROD_W-1:pcd_pkg::RECIP_SH];
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid         = res_valid_q;
  assign result_o.channel_index = res_q.channel_index;
  assign result_o.width         = res_q.width;
  assign result_o.last          = res_q.last;
  assign result_o.error         = res_q.error;

  // ---------------------------------------------------------------------------
  // Channel store
  // ---------------------------------------------------------------------------
  pcd_ram #(
    .WIDTH (pcd_pkg::WIDTH_W),
    .DEPTH (CHANNELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (next_slot_q[ADDR_W-1:0]),
    .wdata_i (quot_q[pcd_pkg::WIDTH_W-1:0]),
    .re_i    (store_re),
    .raddr_i (emit_idx_q),
    .rdata_o (store_rdata)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A store write never goes past the last slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_we |-> (next_slot_q < SLOT_W'(CHANNELS)))
    else $error("channel store written beyond its last slot");

  // An error item carries fixed zero fields and closes with last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.error) |->
      (result_o.last && (result_o.width == '0) && (result_o.channel_index == '0)))
    else $error("error item with nonzero fields or without last");

  // While a frame is read out the slot index has been rewound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pcd_pkg::ST_EMIT_RD) |-> (next_slot_q == '0))
    else $error("slot index not rewound during frame readout");

  // A frame starts at slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == pcd_pkg::ST_DECIDE) && !in_window) |=> (emit_idx_q == '0))
    else $error("frame readout does not start at slot zero");

endmodule

`default_nettype wire
